FILE: design/msicc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msicc_pkg
// Shared types and constants of the MSI snooping cache controller: access
// kinds, line states, bus request codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package msicc_pkg;

	localparam int ADDR_W          = 32;
	localparam int PID_W           = 4;
	localparam int NUM_SETS_DEF    = 64;
	localparam int WAYS_DEF        = 4;
	localparam int BLOCK_BYTES_DEF = 64;

	typedef enum logic [2:0] {
		K_CPU_RD  = 3'd0,
		K_CPU_WR  = 3'd1,
		K_SNP_RD  = 3'd2,
		K_SNP_RDX = 3'd3,
		K_SNP_FL  = 3'd4,
		K_SNP_UPG = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		LS_INV = 2'd0,
		LS_SHD = 2'd1,
		LS_MOD = 2'd2
	} line_state_t;

	typedef enum logic [1:0] {
		BR_NONE = 2'd0,
		BR_READ = 2'd1,
		BR_RDX  = 2'd2
	} bus_req_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;    // write reset row at the sweep index
		logic capture;  // latch input word and read its set
		logic commit;   // write the set back and load the result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: design/msicc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msicc_ctrl
// Sequencer: sweeps the set memory after reset, then takes one word at a
// time through set read and set write-back.
// ----------------------------------------------------------------------------
module msicc_ctrl import msicc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				// hold until the result register can take the word
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

endmodule

FILE: design/msicc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msicc_dp
// Datapath: set memory of tags, line states and LRU ranks, hit and victim
// logic, MSI next state, result register and processor id register.
// ----------------------------------------------------------------------------
module msicc_dp import msicc_pkg::*; #(
	parameter int NUM_SETS    = NUM_SETS_DEF,
	parameter int WAYS        = WAYS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic              cfg_wr_en,
	input  logic [PID_W-1:0]  cfg_wr_data,
	input  logic [2:0]        kind,
	input  logic [ADDR_W-1:0] address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic [1:0]        bus_request,
	output logic [PID_W-1:0]  bus_requester,
	output logic              flush_out,
	output logic              victim_writeback,
	output logic [ADDR_W-1:0] victim_address
);

	localparam int OFF_W    = $clog2(BLOCK_BYTES);
	localparam int SET_BITS = $clog2(NUM_SETS);
	localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W   = WAY_W;

	typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;
	typedef logic [WAYS-1:0][1:0]        st_row_t;
	typedef logic [WAYS-1:0][RANK_W-1:0] lru_row_t;

	tag_row_t tag_mem [NUM_SETS];
	st_row_t  st_mem  [NUM_SETS];
	lru_row_t lru_mem [NUM_SETS];

	tag_row_t          tag_rd_s1, tag_nx;
	st_row_t           st_rd_s1, st_nx;
	lru_row_t          lru_rd_s1, lru_nx, lru_init;
	kind_t             kind_s1;
	logic [SET_W-1:0]  set_s1, in_set, clr_idx_q;
	logic [TAG_W-1:0]  tag_s1, in_tag;
	logic [PID_W-1:0]  pid_q;

	logic              out_valid_q;
	logic              hit_q, flush_q, vwb_q;
	bus_req_t          req_q;
	logic [ADDR_W-1:0] vaddr_q;

	logic [WAYS-1:0]   match, invalid;
	logic [WAY_W-1:0]  hit_way, vict_way, sel_way;
	logic [RANK_W-1:0] old_rank;
	logic              hit_any, hit_c, do_touch, flush_c, vwb_c;
	bus_req_t          req_c;
	logic [ADDR_W-1:0] vaddr_c;

	assign in_set = (SET_BITS == 0) ? '0 : address[OFF_W +: SET_W];
	assign in_tag = address[ADDR_W-1 -: TAG_W];

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			lru_init[w] = RANK_W'(w);
		end
	end

	// sweep index for the reset pass over the set memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_idx_q == SET_W'(NUM_SETS - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_q <= '0;
		end else if (cfg_wr_en) begin
			pid_q <= cfg_wr_data;
		end
	end

	// set memory, one row per set
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			st_mem[clr_idx_q]  <= {WAYS{LS_INV}};
			lru_mem[clr_idx_q] <= lru_init;
		end else if (cmd.commit) begin
			tag_mem[set_s1] <= tag_nx;
			st_mem[set_s1]  <= st_nx;
			lru_mem[set_s1] <= lru_nx;
		end
		if (cmd.capture) begin
			tag_rd_s1 <= tag_mem[in_set];
			st_rd_s1  <= st_mem[in_set];
			lru_rd_s1 <= lru_mem[in_set];
			kind_s1   <= kind_t'(kind);
			set_s1    <= in_set;
			tag_s1    <= in_tag;
		end
	end

	// lookup and victim choice
	always_comb begin
		hit_way  = '0;
		vict_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			invalid[w] = (st_rd_s1[w] == LS_INV);
			match[w]   = !invalid[w] && (tag_rd_s1[w] == tag_s1);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (lru_rd_s1[w] == RANK_W'(WAYS - 1)) begin
				vict_way = WAY_W'(w);
			end
		end
		// lowest invalid way wins over the least recent one
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (invalid[w]) begin
				vict_way = WAY_W'(w);
			end
		end
		hit_any  = |match;
		sel_way  = hit_any ? hit_way : vict_way;
		old_rank = lru_rd_s1[sel_way];
	end

	// msi next state
	always_comb begin
		tag_nx   = tag_rd_s1;
		st_nx    = st_rd_s1;
		lru_nx   = lru_rd_s1;
		hit_c    = hit_any;
		req_c    = BR_NONE;
		flush_c  = 1'b0;
		vwb_c    = 1'b0;
		vaddr_c  = '0;
		do_touch = 1'b0;
		unique case (kind_s1) inside
			K_CPU_RD, K_CPU_WR: begin
				do_touch = 1'b1;
				if (!hit_any) begin
					if (st_rd_s1[vict_way] == LS_MOD) begin
						vwb_c   = 1'b1;
						vaddr_c = (ADDR_W'(tag_rd_s1[vict_way]) << (OFF_W + SET_BITS))
							| (ADDR_W'(set_s1) << OFF_W);
					end
					tag_nx[vict_way] = tag_s1;
					if (kind_s1 == K_CPU_WR) begin
						st_nx[vict_way] = LS_MOD;
						req_c           = BR_RDX;
					end else begin
						st_nx[vict_way] = LS_SHD;
						req_c           = BR_READ;
					end
				end else if (kind_s1 == K_CPU_WR && st_rd_s1[hit_way] == LS_SHD) begin
					st_nx[hit_way] = LS_MOD;
					req_c          = BR_RDX;
				end
			end
			K_SNP_RD: begin
				if (hit_any && st_rd_s1[hit_way] == LS_MOD) begin
					st_nx[hit_way] = LS_SHD;
					flush_c        = 1'b1;
				end
			end
			K_SNP_RDX: begin
				if (hit_any) begin
					flush_c        = (st_rd_s1[hit_way] == LS_MOD);
					st_nx[hit_way] = LS_INV;
				end
			end
			K_SNP_FL, K_SNP_UPG: begin
			end
			default: begin
				// spare kinds report nothing at all
				hit_c = 1'b0;
			end
		endcase
		if (do_touch) begin
			for (int w = 0; w < WAYS; w++) begin
				if (lru_rd_s1[w] < old_rank) begin
					lru_nx[w] = lru_rd_s1[w] + 1'b1;
				end
			end
			lru_nx[sel_way] = '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q   <= hit_c;
			req_q   <= req_c;
			flush_q <= flush_c;
			vwb_q   <= vwb_c;
			vaddr_q <= vaddr_c;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = hit_q;
	assign bus_request      = req_q;
	assign bus_requester    = (req_q != BR_NONE) ? pid_q : '0;
	assign flush_out        = flush_q;
	assign victim_writeback = vwb_q;
	assign victim_address   = vaddr_q;

endmodule

FILE: design/msi_snooping_cache_controller.sv
`timescale 1ns / 1ps
// Flow: a word is accepted in the idle state and its set row read into registers;
// it is committed (set row written back, result registered) once the result
// register is free, and only then is the next word accepted.
// A result waiting in the output register does not hold up the next set read.
// Reset: processor_id clears to 0; then a pass over all NUM_SETS sets marks every
// line invalid and restores the LRU order, with in_stall high.
// ----------------------------------------------------------------------------
// msi_snooping_cache_controller
// Set-associative write-back cache directory with LRU replacement and MSI
// snooping coherence, one processor access or snooped bus operation per word.
// ----------------------------------------------------------------------------
module msi_snooping_cache_controller import msicc_pkg::*; #(
	parameter int NUM_SETS    = NUM_SETS_DEF,
	parameter int WAYS        = WAYS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [PID_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        kind,
	input  logic [ADDR_W-1:0] address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic [1:0]        bus_request,
	output logic [PID_W-1:0]  bus_requester,
	output logic              flush_out,
	output logic              victim_writeback,
	output logic [ADDR_W-1:0] victim_address
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	msicc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	msicc_dp #(
		.NUM_SETS    (NUM_SETS),
		.WAYS        (WAYS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.kind             (kind),
		.address          (address),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hit              (hit),
		.bus_request      (bus_request),
		.bus_requester    (bus_requester),
		.flush_out        (flush_out),
		.victim_writeback (victim_writeback),
		.victim_address   (victim_address)
	);

endmodule
